### sv/acbr_pkg.sv
package acbr_pkg;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_RAW     = 2'd1,
    OP_BOUNDED = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_NONCE_HIGH = 3'd2,
    REG_NONCE_LOW  = 3'd3,
    REG_CLEAR_TAIL = 3'd4
  } reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bound;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e         op;
    logic        zero_bound;
    logic [31:0] bound;
    logic [31:0] threshold;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### sv/acbr_front.sv
module acbr_front import acbr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_DONE
  } fstate_e;

  fstate_e     state_q;
  logic [1:0]  op_q;
  logic [31:0] bound_q;
  logic [32:0] rem_q;
  logic [32:0] num_q;
  logic [5:0]  cnt_q;
  logic [33:0] trial;

  assign in_stall    = (state_q != F_IDLE);
  assign cmd_valid_o = (state_q == F_DONE);
  assign cmd_o.op         = op_e'(op_q);
  assign cmd_o.bound      = bound_q;
  assign cmd_o.zero_bound = (bound_q == 32'd0);
  assign cmd_o.threshold  = rem_q[31:0];

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_q, num_q[32]} - {2'b00, bound_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= 2'd0;
      bound_q <= '0;
      rem_q   <= '0;
      num_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid) begin
            op_q    <= in_data.op;
            bound_q <= in_data.bound;
            rem_q   <= '0;
            num_q   <= 33'h1_0000_0000 - {1'b0, in_data.bound};
            cnt_q   <= 6'd33;
            if (in_data.op == OP_BOUNDED && in_data.bound != 32'd0) begin
              state_q <= F_DIV;
            end else begin
              state_q <= F_DONE;
            end
          end
        end
        F_DIV: begin
          if (!trial[33]) begin
            rem_q <= trial[32:0];
          end else begin
            rem_q <= {rem_q[31:0], num_q[32]};
          end
          num_q <= {num_q[31:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          if (cmd_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/acbr_aes.sv
module acbr_aes import acbr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  input  logic [127:0] block_i,
  output logic         done_o,
  output logic [127:0] block_o
);

  logic [127:0] st_q;
  logic [127:0] rk_q;
  logic [7:0]   rcon_q;
  logic [3:0]   rnd_q;
  logic         busy_q;
  logic [127:0] rk_next;
  logic [127:0] sr;
  logic [127:0] mc;
  logic [7:0]   b [16];
  logic [7:0]   t [16];
  logic [31:0]  w3s;

  function automatic logic [7:0] byte_of(input logic [127:0] v, input int i);
    return v[127 - 8*i -: 8];
  endfunction

  always_comb begin
    w3s = {sbox(rk_q[23:16]) ^ rcon_q, sbox(rk_q[15:8]), sbox(rk_q[7:0]), sbox(rk_q[31:24])};
    rk_next[127:96] = rk_q[127:96] ^ w3s;
    rk_next[95:64]  = rk_q[95:64] ^ rk_next[127:96];
    rk_next[63:32]  = rk_q[63:32] ^ rk_next[95:64];
    rk_next[31:0]   = rk_q[31:0] ^ rk_next[63:32];
    for (int i = 0; i < 16; i++) begin
      b[i] = byte_of(st_q, i);
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[c*4+k] = sbox(b[((c + k) % 4)*4 + k]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      sr[127 - 8*i -: 8] = t[i];
    end
    for (int c = 0; c < 4; c++) begin
      mc[127 - 32*c -: 8] = t[c*4] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3])
                            ^ xtime(t[c*4] ^ t[c*4+1]);
      mc[119 - 32*c -: 8] = t[c*4+1] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3])
                            ^ xtime(t[c*4+1] ^ t[c*4+2]);
      mc[111 - 32*c -: 8] = t[c*4+2] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3])
                            ^ xtime(t[c*4+2] ^ t[c*4+3]);
      mc[103 - 32*c -: 8] = t[c*4+3] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3])
                            ^ xtime(t[c*4+3] ^ t[c*4]);
    end
  end

  assign block_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      rnd_q  <= '0;
      rcon_q <= 8'h01;
      st_q   <= '0;
      rk_q   <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        st_q   <= block_i ^ key_i;
        rk_q   <= key_i;
        rcon_q <= 8'h01;
        rnd_q  <= 4'd1;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        st_q   <= ((rnd_q == 4'd10) ? sr : mc) ^ rk_next;
        rk_q   <= rk_next;
        rcon_q <= xtime(rcon_q);
        rnd_q  <= rnd_q + 4'd1;
        if (rnd_q == 4'd10) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/acbr_back.sv
module acbr_back import acbr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cmd_t          cmd_i,
  input  logic [127:0]  key_i,
  input  logic [127:0]  nonce_i,
  input  logic          clear_tail_i,
  output logic          out_valid,
  input  logic          out_stall,
  output out_word_t     out_data
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_AES,
    B_WORD,
    B_MUL,
    B_CHECK,
    B_OUT
  } bstate_e;

  bstate_e      state_q;
  cmd_t         cmd_q;
  logic [127:0] ctr_q;
  logic [127:0] ks_q;
  logic [2:0]   pos_q;
  logic [31:0]  word_q;
  logic [63:0]  prod_q;
  logic         aes_busy_q;
  logic         aes_start;
  logic         aes_done;
  logic [127:0] aes_blk;
  logic [31:0]  sel_word;

  assign cmd_ready_o = (state_q == B_IDLE) && !(out_valid && out_stall);
  assign aes_start   = (state_q == B_AES) && (pos_q == 3'd4) && !aes_busy_q;
  assign sel_word    = ks_q[127 - 32*pos_q[1:0] -: 32];

  acbr_aes u_aes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aes_start),
    .key_i   (key_i),
    .block_i (ctr_q + 128'd1),
    .done_o  (aes_done),
    .block_o (aes_blk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      ctr_q      <= '0;
      pos_q      <= 3'd4;
      out_valid  <= 1'b0;
      aes_busy_q <= 1'b0;
      cmd_q      <= '0;
      out_data   <= '0;
      ks_q       <= '0;
      word_q     <= '0;
      prod_q     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            cmd_q <= cmd_i;
            case (cmd_i.op)
              OP_RESTART: begin
                ctr_q     <= {nonce_i[127:16], clear_tail_i ? 16'h0 : nonce_i[15:0]};
                pos_q     <= 3'd4;
                out_data  <= '0;
                out_valid <= 1'b1;
              end
              OP_RAW: state_q <= B_AES;
              OP_BOUNDED: begin
                if (cmd_i.zero_bound) begin
                  out_data  <= '{value: 32'd0, status: 1'b1};
                  out_valid <= 1'b1;
                end else begin
                  state_q <= B_AES;
                end
              end
              default: begin
                out_data  <= '0;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        B_AES: begin
          if (pos_q != 3'd4) begin
            state_q <= B_WORD;
          end else if (aes_start) begin
            aes_busy_q <= 1'b1;
            ctr_q      <= ctr_q + 128'd1;
          end else if (aes_done) begin
            aes_busy_q <= 1'b0;
            ks_q       <= aes_blk;
            pos_q      <= 3'd0;
            state_q    <= B_WORD;
          end
        end
        B_WORD: begin
          word_q <= sel_word;
          pos_q  <= pos_q + 3'd1;
          state_q <= (cmd_q.op == OP_RAW) ? B_OUT : B_MUL;
        end
        B_MUL: begin
          prod_q  <= {32'd0, word_q} * {32'd0, cmd_q.bound};
          state_q <= B_CHECK;
        end
        B_CHECK: begin
          if (prod_q[31:0] < cmd_q.threshold) begin
            state_q <= B_AES;
          end else begin
            word_q  <= prod_q[63:32];
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (!(out_valid && out_stall)) begin
            out_data  <= '{value: word_q, status: 1'b0};
            out_valid <= 1'b1;
            state_q   <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= 3'd4)
    else $error("word position out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_done |-> state_q == B_AES)
    else $error("cipher finished outside refill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

### sv/aes_ctr_bounded_random_unit.sv
// restart, zero bound or unused op are answered from the back's idle state; a raw
// draw takes a word from the keystream buffer, refilling it first by running the
// 10-round iterative cipher; a bounded draw adds a serial remainder in the front
// and draws again when a word is rejected; one item in flight per stage
// reset: counter zero, keystream buffer empty, others zero; cipher round constant 1
module aes_ctr_bounded_random_unit import acbr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [63:0] key_hi_q, key_lo_q, nonce_hi_q, nonce_lo_q;
  logic        clear_tail_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q     <= '0;
      key_lo_q     <= '0;
      nonce_hi_q   <= '0;
      nonce_lo_q   <= '0;
      clear_tail_q <= 1'b0;
    end else if (cfg_we) begin
      case (reg_e'(cfg_idx))
        REG_KEY_HIGH:   key_hi_q     <= cfg_wdata;
        REG_KEY_LOW:    key_lo_q     <= cfg_wdata;
        REG_NONCE_HIGH: nonce_hi_q   <= cfg_wdata;
        REG_NONCE_LOW:  nonce_lo_q   <= cfg_wdata;
        REG_CLEAR_TAIL: clear_tail_q <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  acbr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  acbr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .key_i        ({key_hi_q, key_lo_q}),
    .nonce_i      ({nonce_hi_q, nonce_lo_q}),
    .clear_tail_i (clear_tail_q),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
